FILE: sv/pbd_pkg.sv
package pbd_pkg;

  // Sensor sample width default
  localparam int SAMPLE_BITS_DEF = 12;

  // Threshold register
  localparam int             THR_W     = 12;
  localparam logic [THR_W-1:0] THR_RESET = 12'd2000;

  // Result field widths
  localparam int BAT_W      = 16;
  localparam int POS_W      = 3;
  localparam int DIFF_OUT_W = 13;
  localparam int KIND_W     = 2;
  localparam int OUT_FIELDS_W = 1 + 1 + BAT_W + 1 + POS_W + 2 * DIFF_OUT_W + 1 + 1;
  localparam int OUT_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Ball position codes
  localparam logic [POS_W-1:0] POS_SECOND     = 3'd0;
  localparam logic [POS_W-1:0] POS_FIRST_ONLY = 3'd5;

  // Message kinds carried on tuser
  localparam logic [KIND_W-1:0] MSG_SPEED = 2'd0;
  localparam logic [KIND_W-1:0] MSG_VOLT  = 2'd1;
  localparam logic [KIND_W-1:0] MSG_BALL  = 2'd2;

  // Battery average: q = (90*old + 50 + floor(363*1024*s / 2^SB)) / 100
  localparam int AVG_X_W         = 23;
  localparam int AVG_T_W         = 19;
  localparam int AVG_NEW_SHIFT   = 10;
  localparam int AVG_RECIP_W     = 26;
  localparam int AVG_RECIP_SHIFT = 32;
  localparam int AVG_Q_W         = AVG_X_W + AVG_RECIP_W - AVG_RECIP_SHIFT;
  localparam logic [AVG_X_W-1:0]     AVG_OLD_MUL = 23'd90;
  localparam logic [AVG_X_W-1:0]     AVG_ROUND   = 23'd50;
  localparam int                     AVG_NEW_MUL = 363;
  // ceil(2^32 / 100), exact for every sum below 2^30
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP   = 26'd42949673;

  // Emitter sequencing phase
  typedef enum logic [1:0] {
    PH_REF  = 2'd0,
    PH_LIT1 = 2'd1,
    PH_LIT2 = 2'd2
  } phase_t;

endpackage

FILE: sv/photo_ball_detect_sequencer.sv
// Photo ball detector sequencer. Every input beat is one tick and yields exactly one
// result beat. Ticks cycle through three phases: the first drives emitter B and stores
// the reference photo sample (speed slot), the second drives emitter A, stores the
// first lit sample and updates the battery average (voltage report), the third turns
// both emitters off, forms reference-minus-lit differences, and reports the ball code
// (ball report). LEDs follow the held differences on every tick. The block takes a
// beat every clock cycle unless the result side stalls it; a result beat passes through
// the input register, then the compute register, then the output register, with the
// battery divide by 100 done as a reciprocal multiply in the last stage.
// detect_threshold is written through cfg_wr_en/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module photo_ball_detect_sequencer
  import pbd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [THR_W-1:0]                      cfg_wdata,   // detect_threshold
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // photo_sample, battery_sample, sensor_disable, zero pad
  input  logic [((2*SAMPLE_BITS+8)/8)*8-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // emitter_a, emitter_b, battery_level, ball_present, ball_position,
  // diff_first, diff_second, led_first, led_second, zero pad
  output logic [OUT_W-1:0]                      out_tdata,
  output logic [KIND_W-1:0]                     out_tuser    // msg_kind
);

  localparam int SB     = SAMPLE_BITS;
  localparam int CMP_W  = (SB + 1 > DIFF_OUT_W) ? SB + 2 : DIFF_OUT_W + 1;
  localparam int PROD_W = SB + 9;
  localparam int WIDE_W = PROD_W + AVG_NEW_SHIFT;
  localparam int MUL_W  = AVG_X_W + AVG_RECIP_W;

  typedef struct packed {
    logic                  ea;
    logic                  eb;
    logic [KIND_W-1:0]     kind;
    logic                  present;
    logic [POS_W-1:0]      pos;
    logic [DIFF_OUT_W-1:0] diff0;
    logic [DIFF_OUT_W-1:0] diff1;
    logic                  led_first;
    logic                  led_second;
    logic                  upd;
    logic [AVG_X_W-1:0]    x;
  } mid_t;

  typedef struct packed {
    logic                  ea;
    logic                  eb;
    logic [KIND_W-1:0]     kind;
    logic [BAT_W-1:0]      bat;
    logic                  present;
    logic [POS_W-1:0]      pos;
    logic [DIFF_OUT_W-1:0] diff0;
    logic [DIFF_OUT_W-1:0] diff1;
    logic                  led_first;
    logic                  led_second;
  } res_t;

  // Configuration and tick state
  logic [THR_W-1:0]        thr_r;
  phase_t                  phase_r, phase_nxt;
  logic [SB-1:0]           ref_r, ref_nxt;
  logic [SB-1:0]           lit_r, lit_nxt;
  logic signed [CMP_W-1:0] diff_hold_r [2];
  logic signed [CMP_W-1:0] diff_hold_nxt [2];
  logic [BAT_W-1:0]        vavg_r, vavg_nxt;

  // Pipeline
  logic          a_v_r, b_v_r, out_v_r;
  logic [SB-1:0] a_photo_r, a_batt_r;
  logic          a_dis_r;
  mid_t          b_r, b_nxt;
  res_t          out_r, out_nxt;
  logic          rdy_out, rdy_b, a_adv, b_adv, in_acc, item_ok;

  // Combinational work signals
  logic signed [SB:0]        d_first, d_second;
  logic signed [CMP_W-1:0]   thr_s;
  logic                      below0, below1;
  logic [PROD_W-1:0]         batt_prod;
  logic [WIDE_W-1:0]         batt_wide;
  logic [AVG_T_W-1:0]        batt_t;
  logic [MUL_W-1:0]          avg_mul;
  logic [AVG_Q_W-1:0]        avg_q;

  // Flow control: each stage moves when the next one is free or moving
  assign rdy_out   = !out_v_r || out_tready;
  assign b_adv     = b_v_r && rdy_out;
  assign rdy_b     = !b_v_r || rdy_out;
  assign a_adv     = a_v_r && rdy_b;
  assign in_tready = !a_v_r || rdy_b;
  assign in_acc    = in_tvalid && in_tready;

  // Phase step: emitters, sample capture, differences and ball code
  always_comb begin
    phase_nxt        = phase_r;
    ref_nxt          = ref_r;
    lit_nxt          = lit_r;
    diff_hold_nxt[0] = diff_hold_r[0];
    diff_hold_nxt[1] = diff_hold_r[1];
    item_ok          = 1'b1;
    b_nxt            = '0;
    d_first          = $signed({1'b0, ref_r}) - $signed({1'b0, lit_r});
    d_second         = $signed({1'b0, ref_r}) - $signed({1'b0, a_photo_r});
    unique case (phase_r)
      PH_REF: begin
        b_nxt.eb   = 1'b1;
        b_nxt.kind = MSG_SPEED;
        ref_nxt    = a_photo_r;
        phase_nxt  = PH_LIT1;
      end
      PH_LIT1: begin
        b_nxt.ea   = 1'b1;
        b_nxt.kind = MSG_VOLT;
        b_nxt.upd  = 1'b1;
        lit_nxt    = a_photo_r;
        phase_nxt  = PH_LIT2;
      end
      PH_LIT2: begin
        b_nxt.kind = MSG_BALL;
        if (a_dis_r) begin
          diff_hold_nxt[0] = '0;
          diff_hold_nxt[1] = '0;
        end else begin
          diff_hold_nxt[0] = CMP_W'(d_first);
          diff_hold_nxt[1] = CMP_W'(d_second);
        end
        phase_nxt = PH_REF;
      end
      default: begin
        // unused phase code: return to start, emit nothing
        item_ok   = 1'b0;
        phase_nxt = PH_REF;
      end
    endcase

    // Compare held differences against the threshold (signed)
    thr_s  = $signed({{(CMP_W-THR_W){1'b0}}, thr_r});
    below0 = diff_hold_nxt[0] < thr_s;
    below1 = diff_hold_nxt[1] < thr_s;
    b_nxt.led_first  = below1;
    b_nxt.led_second = below0;
    b_nxt.diff0      = diff_hold_nxt[0][DIFF_OUT_W-1:0];
    b_nxt.diff1      = diff_hold_nxt[1][DIFF_OUT_W-1:0];
    if (phase_r == PH_LIT2) begin
      if (below1) begin
        b_nxt.present = 1'b1;
        b_nxt.pos     = POS_SECOND;
      end else if (below0) begin
        b_nxt.present = 1'b1;
        b_nxt.pos     = POS_FIRST_ONLY;
      end
    end

    // Battery sum ahead of the divide by 100
    batt_prod = PROD_W'(a_batt_r) * PROD_W'(AVG_NEW_MUL);
    batt_wide = {batt_prod, {AVG_NEW_SHIFT{1'b0}}};
    batt_t    = batt_wide[SB +: AVG_T_W];
    b_nxt.x   = AVG_X_W'(vavg_r) * AVG_OLD_MUL + AVG_X_W'(batt_t) + AVG_ROUND;
  end

  // Divide by 100 through the reciprocal, saturate, assemble the result
  always_comb begin
    avg_mul = MUL_W'(b_r.x) * MUL_W'(AVG_RECIP);
    avg_q   = avg_mul[MUL_W-1:AVG_RECIP_SHIFT];
    vavg_nxt = vavg_r;
    if (b_r.upd) begin
      if (avg_q > AVG_Q_W'({BAT_W{1'b1}})) begin
        vavg_nxt = {BAT_W{1'b1}};
      end else begin
        vavg_nxt = avg_q[BAT_W-1:0];
      end
    end
    out_nxt.ea         = b_r.ea;
    out_nxt.eb         = b_r.eb;
    out_nxt.kind       = b_r.kind;
    out_nxt.bat        = vavg_nxt;
    out_nxt.present    = b_r.present;
    out_nxt.pos        = b_r.pos;
    out_nxt.diff0      = b_r.diff0;
    out_nxt.diff1      = b_r.diff1;
    out_nxt.led_first  = b_r.led_first;
    out_nxt.led_second = b_r.led_second;
  end

  // Control state and valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r          <= THR_RESET;
      phase_r        <= PH_REF;
      ref_r          <= '0;
      lit_r          <= '0;
      diff_hold_r[0] <= '0;
      diff_hold_r[1] <= '0;
      vavg_r         <= '0;
      a_v_r          <= 1'b0;
      b_v_r          <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wdata;
      end
      if (a_adv) begin
        phase_r        <= phase_nxt;
        ref_r          <= ref_nxt;
        lit_r          <= lit_nxt;
        diff_hold_r[0] <= diff_hold_nxt[0];
        diff_hold_r[1] <= diff_hold_nxt[1];
      end
      if (b_adv) begin
        vavg_r <= vavg_nxt;
      end
      if (in_acc) begin
        a_v_r <= 1'b1;
      end else if (a_adv) begin
        a_v_r <= 1'b0;
      end
      if (a_adv) begin
        b_v_r <= item_ok;
      end else if (b_adv) begin
        b_v_r <= 1'b0;
      end
      if (b_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_photo_r <= in_tdata[SB-1:0];
      a_batt_r  <= in_tdata[2*SB-1:SB];
      a_dis_r   <= in_tdata[2*SB];
    end
    if (a_adv) begin
      b_r <= b_nxt;
    end
    if (b_adv) begin
      out_r <= out_nxt;
    end
  end

  // Drive the result channel
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {{(OUT_W-OUT_FIELDS_W){1'b0}},
                       out_r.led_second, out_r.led_first,
                       out_r.diff1, out_r.diff0,
                       out_r.pos, out_r.present,
                       out_r.bat, out_r.eb, out_r.ea};

  // Emitter A is driven exactly on voltage report ticks
  a_emit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.ea == (out_r.kind == MSG_VOLT)))
    else $error("emitter A level does not match message kind");

  // Ball code only appears in ball reports
  a_ball_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.kind != MSG_BALL) |-> !out_r.present && (out_r.pos == POS_SECOND))
    else $error("ball code outside ball report");

  // A present ball sits at one of the two positions
  a_ball_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.present |-> (out_r.pos == POS_SECOND) || (out_r.pos == POS_FIRST_ONLY))
    else $error("ball position code out of range");

  // Battery average moves only when a voltage report leaves the compute stage
  a_vavg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(b_adv && b_r.upd) |=> $stable(vavg_r))
    else $error("battery average changed outside a voltage update");

endmodule

FILE: verif/photo_ball_detect_checker.sv
`timescale 1ns / 1ps

// Watches the sample and result streams of the ball detect sequencer, keeps its
// own copy of the phase, held samples, battery average and differences, and
// compares every result beat field by field with the oldest predicted tick.
module photo_ball_detect_checker
  import pbd_pkg::*;
#(
  parameter int IN_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [THR_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,
  input  logic [KIND_W-1:0] out_tuser,
  output int                pending_cnt,
  output int                fail_cnt,
  output int                checked_cnt,
  output int                hit_cnt
);

  localparam int SB       = SAMPLE_BITS_DEF;
  localparam int OFF_BAT  = 2;
  localparam int OFF_PRES = OFF_BAT + BAT_W;
  localparam int OFF_POS  = OFF_PRES + 1;
  localparam int OFF_D1   = OFF_POS + POS_W;
  localparam int OFF_D2   = OFF_D1 + DIFF_OUT_W;
  localparam int OFF_LED1 = OFF_D2 + DIFF_OUT_W;
  localparam int OFF_LED2 = OFF_LED1 + 1;

  typedef struct {
    logic                         emit_a;
    logic                         emit_b;
    logic [KIND_W-1:0]            kind;
    logic [BAT_W-1:0]             level;
    logic                         present;
    logic [POS_W-1:0]             pos;
    logic signed [DIFF_OUT_W-1:0] d_first;
    logic signed [DIFF_OUT_W-1:0] d_second;
    logic                         led_first;
    logic                         led_second;
  } tick_result_t;

  tick_result_t tick_q[$];

  // Mirrored block state
  logic [THR_W-1:0]             threshold;
  phase_t                       phase;
  logic [SB-1:0]                ref_sample;
  logic [SB-1:0]                lit_sample;
  logic [BAT_W-1:0]             volt_avg;
  logic signed [DIFF_OUT_W-1:0] diff_first;
  logic signed [DIFF_OUT_W-1:0] diff_second;

  // 0.9*old + 0.1*scaled sample, rounded half up, saturated
  function automatic logic [BAT_W-1:0] battery_avg_next(input logic [BAT_W-1:0] old_avg,
                                                        input logic [SB-1:0] sample);
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    den = 64'd100 << SB;
    num = (64'(old_avg) * 64'd90 << SB) + 64'd363 * 64'd1024 * 64'(sample);
    q = (num + den / 2) / den;
    return (q > 64'd65535) ? 16'hFFFF : q[BAT_W-1:0];
  endfunction

  // Signed difference against the unsigned threshold
  function automatic logic below_thr(input logic signed [DIFF_OUT_W-1:0] d);
    return int'(d) < int'(threshold);
  endfunction

  // Advance one tick and return the result it produces
  function automatic tick_result_t step_sequencer(input logic [SB-1:0] photo,
                                                  input logic [SB-1:0] batt,
                                                  input logic dis);
    tick_result_t r;
    r.present = 1'b0;
    r.pos     = '0;
    case (phase)
      PH_REF: begin
        r.emit_a   = 1'b0;
        r.emit_b   = 1'b1;
        r.kind     = MSG_SPEED;
        ref_sample = photo;
        phase      = PH_LIT1;
      end
      PH_LIT1: begin
        r.emit_a   = 1'b1;
        r.emit_b   = 1'b0;
        r.kind     = MSG_VOLT;
        lit_sample = photo;
        volt_avg   = battery_avg_next(volt_avg, batt);
        phase      = PH_LIT2;
      end
      default: begin
        r.emit_a = 1'b0;
        r.emit_b = 1'b0;
        r.kind   = MSG_BALL;
        if (dis) begin
          diff_first  = '0;
          diff_second = '0;
        end else begin
          diff_first  = $signed({1'b0, ref_sample}) - $signed({1'b0, lit_sample});
          diff_second = $signed({1'b0, ref_sample}) - $signed({1'b0, photo});
        end
        if (below_thr(diff_second)) begin
          r.present = 1'b1;
          r.pos     = POS_SECOND;
        end else if (below_thr(diff_first)) begin
          r.present = 1'b1;
          r.pos     = POS_FIRST_ONLY;
        end
        phase = PH_REF;
      end
    endcase
    r.level      = volt_avg;
    r.d_first    = diff_first;
    r.d_second   = diff_second;
    r.led_first  = below_thr(diff_second);
    r.led_second = below_thr(diff_first);
    return r;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    fail_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                checked_cnt, name, got, want));
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    logic [OUT_W-1:0] d;
    if (!rst_n) begin
      threshold   = THR_RESET;
      phase       = PH_REF;
      ref_sample  = '0;
      lit_sample  = '0;
      volt_avg    = '0;
      diff_first  = '0;
      diff_second = '0;
      tick_q.delete();
    end else begin
      if (cfg_wr_en)
        threshold = cfg_wdata;
      // Compare the result beat with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (tick_q.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%0h with no tick outstanding", out_tdata));
        end else begin
          want = tick_q.pop_front();
          d    = out_tdata;
          check_field("emitter_a", int'(d[0]), int'(want.emit_a));
          check_field("emitter_b", int'(d[1]), int'(want.emit_b));
          check_field("msg_kind", int'(out_tuser), int'(want.kind));
          check_field("battery_level", int'(d[OFF_BAT +: BAT_W]), int'(want.level));
          check_field("ball_present", int'(d[OFF_PRES]), int'(want.present));
          check_field("ball_position", int'(d[OFF_POS +: POS_W]), int'(want.pos));
          check_field("diff_first", int'($signed(d[OFF_D1 +: DIFF_OUT_W])),
                      int'(want.d_first));
          check_field("diff_second", int'($signed(d[OFF_D2 +: DIFF_OUT_W])),
                      int'(want.d_second));
          check_field("led_first", int'(d[OFF_LED1]), int'(want.led_first));
          check_field("led_second", int'(d[OFF_LED2]), int'(want.led_second));
          if (want.kind == MSG_BALL && want.present)
            hit_cnt++;
          checked_cnt++;
        end
      end
      // Predict the tick carried by an accepted sample beat
      if (in_tvalid && in_tready)
        tick_q.push_back(step_sequencer(in_tdata[SB-1:0], in_tdata[2*SB-1:SB], in_tdata[2*SB]));
    end
    pending_cnt = tick_q.size();
  end

endmodule

FILE: verif/photo_ball_detect_sequencer_tb.sv
`timescale 1ns / 1ps

module photo_ball_detect_sequencer_tb
  import pbd_pkg::*;
();

  localparam int  SB        = SAMPLE_BITS_DEF;
  localparam int  IN_W      = ((2 * SB + 8) / 8) * 8;
  localparam int  SEG_TICKS = 215;
  localparam int  NUM_SEGS  = 6;
  localparam real LIMIT_NS  = 4000000.0;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_wr_en  = 1'b0;
  logic [THR_W-1:0]  cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic [KIND_W-1:0] out_tuser;

  int pending_cnt;
  int fail_cnt;
  int checked_cnt;
  int hit_cnt;

  // Stimulus-side bookkeeping
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  int               ticks_sent  = 0;
  int               thr_writes  = 0;
  int               tick_phase  = 0;
  logic [SB-1:0]    ref_photo   = '0;
  logic [THR_W-1:0] cur_thr     = THR_RESET;

  photo_ball_detect_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  photo_ball_detect_checker #(.IN_W(IN_W)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .pending_cnt (pending_cnt),
    .fail_cnt    (fail_cnt),
    .checked_cnt (checked_cnt),
    .hit_cnt     (hit_cnt)
  );

  always #2 clk = ~clk;

  // Result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Hand one tick to the block, idling at random first
  task automatic send_tick(input logic [SB-1:0] photo, input logic [SB-1:0] batt,
                           input logic dis);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - 2 * SB - 1){1'b0}}, dis, batt, photo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (tick_phase == 0)
      ref_photo = photo;
    tick_phase = (tick_phase + 1) % 3;
    ticks_sent++;
  endtask

  // Random tick, biased toward differences close to zero and to the threshold
  task automatic send_random_tick();
    logic [SB-1:0] photo;
    logic [SB-1:0] batt;
    int            pick;
    int            near;
    pick  = $urandom_range(0, 9);
    photo = SB'($urandom);
    near  = int'(ref_photo);
    if (pick == 0)
      photo = '0;
    else if (pick == 1)
      photo = '1;
    else if (tick_phase != 0 && pick <= 4)
      near = int'(ref_photo) + int'($urandom_range(0, 160)) - 80;
    else if (tick_phase != 0 && pick <= 6)
      near = int'(ref_photo) - int'(cur_thr) + int'($urandom_range(0, 8)) - 4;
    if (tick_phase != 0 && pick >= 2 && pick <= 6)
      photo = (near < 0) ? '0 : (near > (1 << SB) - 1) ? '1 : near[SB-1:0];
    pick = $urandom_range(0, 9);
    batt = (pick == 0) ? '0 : (pick == 1) ? '1 : SB'($urandom);
    send_tick(photo, batt, $urandom_range(0, 7) == 0);
  endtask

  // Hold the sender until every tick has come back, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_cnt != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_thr = value;
    thr_writes++;
  endtask

  initial begin
    logic [THR_W-1:0] seg_thr;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks at the reset threshold, three per cycle
    tx_idle_pct = 18;
    rx_idle_pct = 57;
    // no ball: large positive differences, full-scale battery
    send_tick('1, '0, 1'b0);  send_tick('0, '1, 1'b0);  send_tick('0, '0, 1'b0);
    // most negative differences: second hit
    send_tick('0, '1, 1'b0);  send_tick('1, '0, 1'b0);  send_tick('1, '1, 1'b0);
    // only the first difference below threshold
    send_tick(12'd3000, '0, 1'b0);  send_tick(12'd2000, '1, 1'b0);
    send_tick(12'd0, '0, 1'b0);
    // second difference just below threshold
    send_tick(12'd3000, '1, 1'b0);  send_tick(12'd0, '1, 1'b0);
    send_tick(12'd1001, '0, 1'b0);
    // both differences equal to threshold: no ball
    send_tick(12'd3000, '1, 1'b0);  send_tick(12'd1000, '1, 1'b0);
    send_tick(12'd1000, '1, 1'b0);
    // disabled sensor: zero differences still compared
    send_tick('1, 12'd2048, 1'b0);  send_tick('0, 12'd2048, 1'b0);
    send_tick('0, '1, 1'b1);
    // disable outside the ball phase has no effect
    send_tick('1, '1, 1'b1);  send_tick('0, '1, 1'b1);  send_tick('1, '0, 1'b0);
    // real differences again, with disable set only outside the ball phase
    send_tick(12'd2500, 12'd1, 1'b1);  send_tick(12'd2499, 12'd4094, 1'b1);
    send_tick(12'd4095, 12'd7, 1'b0);
    drain();

    // Random segments, each at its own threshold, in pairs sharing one of three idle profiles
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        0:       seg_thr = '0;
        1:       seg_thr = '1;
        2:       seg_thr = THR_W'($urandom);
        3:       seg_thr = 12'd1;
        4:       seg_thr = THR_W'($urandom_range(1500, 2500));
        default: seg_thr = THR_RESET;
      endcase
      tx_idle_pct = (seg < 2) ? 18 : (seg < 4) ? 57 : 0;
      rx_idle_pct = (seg < 2) ? 57 : (seg < 4) ? 18 : 0;
      write_threshold(seg_thr);
      for (int i = 0; i < SEG_TICKS; i++) begin
        // hold off once mid-stream until all outstanding results return
        if (seg == 2 && i == SEG_TICKS / 2)
          drain();
        send_random_tick();
      end
      drain();
    end

    $display("Ran %0d ticks over %0d threshold settings and three idle profiles.",
             ticks_sent, thr_writes + 1);
    $display("Checked %0d result beats, %0d of them ball reports with a hit.",
             checked_cnt, hit_cnt);
    if (fail_cnt == 0)
      $display("** photo_ball_detect_sequencer: PASSED **");
    else
      $display("** photo_ball_detect_sequencer: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d results outstanding.", pending_cnt);
    $display("** photo_ball_detect_sequencer: FAILED **");
    $finish;
  end

endmodule
